// ----- rtl/bbpmc_pkg.sv -----
// Shared constants for the Bayer bad-pixel median correction block.
// No dependencies; used by bayer_bad_pixel_median_correct.
package bbpmc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int PIXEL_BITS = 16;
   localparam int PTR_BITS   = $clog2(MAX_WIDTH);
   localparam int ENTRY_BITS = PIXEL_BITS + 1;
   localparam int LINES      = 4;
   localparam int WIN        = 5;
   localparam int CAND       = 8;
   localparam int CNT_BITS   = 24;
   localparam int CSR_BITS   = 12;

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_GREEN_EVEN   = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef logic [ENTRY_BITS-1:0] entry_type;

endpackage

// ----- rtl/bayer_bad_pixel_median_correct.sv -----
// Top level of the Bayer bad-pixel median correction block.
// Depends on bbpmc_pkg for constants and the store entry type.

// Takes one raster pixel beat per clock while the result side keeps up, and
// returns each pixel 2*width+2 beats later, so the first result of a frame
// appears once 2*width+3 beats have been taken; send 2*width+2 flush beats
// after a frame to drain its tail. Four line buffers in a single block RAM
// (one read and one write a beat) feed a 5x5 window; the window, the neighbor
// selection and a rank-based median settle between the window registers and
// the result register, so a beat is taken in every cycle while the result
// side keeps up, and a result is presented from the result register, which
// loads from the window registers. frame_end rides on rsp_tlast.
module bayer_bad_pixel_median_correct (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pixel_value
   input  logic [1:0]  req_tuser,   // [0] command, [1] is_bad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] pixel_out
   output logic [1:0]  rsp_tuser,   // [0] was_corrected, [1] no_neighbours
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int EB = bbpmc_pkg::ENTRY_BITS;
   localparam int PB = bbpmc_pkg::PIXEL_BITS;
   localparam int LB = bbpmc_pkg::LINES * bbpmc_pkg::ENTRY_BITS;

   logic [11:0] width_ff, height_ff;
   logic        green_even_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 12'd1024;
         height_ff     <= 12'd1024;
         green_even_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            bbpmc_pkg::REG_FRAME_WIDTH:  width_ff      <= csr_wdata;
            bbpmc_pkg::REG_FRAME_HEIGHT: height_ff     <= csr_wdata;
            bbpmc_pkg::REG_GREEN_EVEN:   green_even_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [11:0] eff_w, eff_h;
   logic [12:0] delay;
   assign eff_w = (width_ff == 12'd0) ? 12'd1 :
                  (width_ff > 12'(bbpmc_pkg::MAX_WIDTH)) ? 12'(bbpmc_pkg::MAX_WIDTH) : width_ff;
   assign eff_h = (height_ff == 12'd0) ? 12'd1 : height_ff;
   assign delay = {eff_w, 1'b0} + 13'd2;

   logic accept, s2_take;
   logic s1_valid_ff, rsp_valid_ff;

   assign s2_take    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_take;
   assign accept     = req_tvalid && req_tready;

   // line buffers and window
   logic [LB-1:0]                   line_mem [bbpmc_pkg::MAX_WIDTH];
   logic [LB-1:0]                   rd_ff;
   bbpmc_pkg::entry_type            in_ff, in_entry;
   logic [bbpmc_pkg::PTR_BITS-1:0]  ptr_ff, ptr_q_ff, ptr_in;
   bbpmc_pkg::entry_type            win_ff [bbpmc_pkg::WIN][bbpmc_pkg::WIN-1];
   bbpmc_pkg::entry_type            head [bbpmc_pkg::WIN];

   assign in_entry = (req_tuser[0] == bbpmc_pkg::CMD_FLUSH) ? '0 :
                     {req_tuser[1], req_tdata[PB-1:0]};

   always_ff @(posedge clock) begin
      if (accept) begin
         if (ptr_ff == ptr_q_ff) begin
            rd_ff <= {rd_ff[LB-EB-1:0], in_ff};
         end else begin
            rd_ff <= line_mem[ptr_ff];
         end
         line_mem[ptr_q_ff] <= {rd_ff[LB-EB-1:0], in_ff};
      end
   end

   always_comb begin
      head[0] = in_ff;
      for (int r = 1; r < bbpmc_pkg::WIN; r++) begin
         head[r] = rd_ff[(r-1)*EB +: EB];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= in_entry;
         for (int r = 0; r < bbpmc_pkg::WIN; r++) begin
            win_ff[r][0] <= head[r];
            for (int c = 1; c < bbpmc_pkg::WIN - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c-1];
            end
         end
      end
   end

   // output position tracking
   logic [bbpmc_pkg::CNT_BITS-1:0] count_ff, count_inc, count_in;
   logic [10:0] x_ff, x_in;
   logic [11:0] y_ff, y_in;
   logic        due, last_now, row_end;
   logic [10:0] s1_x_ff;
   logic [11:0] s1_y_ff;
   logic        s1_last_ff, s1_valid_in;

   assign count_inc = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign due       = count_inc > {11'd0, delay};
   assign row_end   = ({1'b0, x_ff} + 12'd1) >= eff_w;
   assign last_now  = (({1'b0, y_ff} + 13'd1) >= {1'b0, eff_h}) && row_end;
   assign ptr_in    = ((due && last_now) || (({1'b0, ptr_ff} + 12'd1) >= eff_w)) ? '0 :
                      ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (accept) begin
         count_in = count_inc;
         if (due) begin
            if (last_now) begin
               count_in = '0;
               x_in     = '0;
               y_in     = '0;
            end else if (row_end) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
      end
      s1_valid_in = accept ? due : (s1_valid_ff && !s2_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         ptr_ff      <= '0;
         ptr_q_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            ptr_ff   <= ptr_in;
            ptr_q_ff <= ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff    <= x_ff;
         s1_y_ff    <= y_ff;
         s1_last_ff <= last_now;
      end
   end

   // neighbor selection and median
   bbpmc_pkg::entry_type view [bbpmc_pkg::WIN][bbpmc_pkg::WIN];
   bbpmc_pkg::entry_type cand [bbpmc_pkg::CAND];
   logic [bbpmc_pkg::CAND-1:0] in_frame, cand_ok;
   logic [3:0]  n_ok, target;
   logic [3:0]  rank [bbpmc_pkg::CAND];
   logic [PB-1:0] med, pix_res;
   logic xm1, xm2, xp1, xp2, ym1, ym2, yp1, yp2, is_green, center_bad;
   logic corr_res, lonely_res;

   assign xm1 = s1_x_ff >= 11'd1;
   assign xm2 = s1_x_ff >= 11'd2;
   assign xp1 = ({1'b0, s1_x_ff} + 12'd1) < eff_w;
   assign xp2 = ({1'b0, s1_x_ff} + 12'd2) < eff_w;
   assign ym1 = s1_y_ff >= 12'd1;
   assign ym2 = s1_y_ff >= 12'd2;
   assign yp1 = ({1'b0, s1_y_ff} + 13'd1) < {1'b0, eff_h};
   assign yp2 = ({1'b0, s1_y_ff} + 13'd2) < {1'b0, eff_h};
   assign is_green = ((s1_x_ff[0] ^ s1_y_ff[0]) == 1'b0) == green_even_ff;

   always_comb begin
      for (int r = 0; r < bbpmc_pkg::WIN; r++) begin
         view[r][0] = head[r];
         for (int c = 1; c < bbpmc_pkg::WIN; c++) begin
            view[r][c] = win_ff[r][c-1];
         end
      end
      if (is_green) begin
         cand[0] = view[3][3];  in_frame[0] = xm1 && ym1;
         cand[1] = view[3][1];  in_frame[1] = xp1 && ym1;
         cand[2] = view[1][3];  in_frame[2] = xm1 && yp1;
         cand[3] = view[1][1];  in_frame[3] = xp1 && yp1;
         cand[4] = '0;          in_frame[4] = 1'b0;
         cand[5] = '0;          in_frame[5] = 1'b0;
         cand[6] = '0;          in_frame[6] = 1'b0;
         cand[7] = '0;          in_frame[7] = 1'b0;
      end else begin
         cand[0] = view[4][4];  in_frame[0] = xm2 && ym2;
         cand[1] = view[4][2];  in_frame[1] = ym2;
         cand[2] = view[4][0];  in_frame[2] = xp2 && ym2;
         cand[3] = view[2][4];  in_frame[3] = xm2;
         cand[4] = view[2][0];  in_frame[4] = xp2;
         cand[5] = view[0][4];  in_frame[5] = xm2 && yp2;
         cand[6] = view[0][2];  in_frame[6] = yp2;
         cand[7] = view[0][0];  in_frame[7] = xp2 && yp2;
      end
      for (int i = 0; i < bbpmc_pkg::CAND; i++) begin
         cand_ok[i] = in_frame[i] && !cand[i][PB];
      end
      n_ok   = 4'($countones(cand_ok));
      target = n_ok >> 1;
      for (int i = 0; i < bbpmc_pkg::CAND; i++) begin
         rank[i] = '0;
         for (int j = 0; j < bbpmc_pkg::CAND; j++) begin
            if (cand_ok[j] && ((cand[j][PB-1:0] < cand[i][PB-1:0]) ||
                               ((cand[j][PB-1:0] == cand[i][PB-1:0]) && (j < i)))) begin
               rank[i] = rank[i] + 4'd1;
            end
         end
      end
      med = '0;
      for (int i = 0; i < bbpmc_pkg::CAND; i++) begin
         if (cand_ok[i] && (rank[i] == target)) begin
            med = cand[i][PB-1:0];
         end
      end
      center_bad = view[2][2][PB];
      corr_res   = center_bad && (n_ok != 4'd0);
      lonely_res = center_bad && (n_ok == 4'd0);
      pix_res    = corr_res ? med : view[2][2][PB-1:0];
   end

   // result register
   logic [PB-1:0] rsp_pix_ff;
   logic          rsp_corr_ff, rsp_lonely_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         rsp_pix_ff    <= pix_res;
         rsp_corr_ff   <= corr_res;
         rsp_lonely_ff <= lonely_res;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = {rsp_lonely_ff, rsp_corr_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready) else $error("input stalled with empty stage");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_corr_ff && rsp_lonely_ff)) else $error("both flags set");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && due && last_now) |=> (count_ff == '0 && x_ff == '0 && y_ff == '0))
      else $error("counters not cleared at frame end");

   a_take_loads_output: assert property (@(posedge clock) disable iff (reset)
      s2_take |=> rsp_valid_ff) else $error("result lost");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for bayer_bad_pixel_median_correct: streams Bayer frames with defect marks
// and checks every output pixel and its flags against an in-bench window model with median logic.
// Depends on bbpmc_pkg and the block's RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 4 * bbpmc_pkg::MAX_WIDTH + 8;

   typedef struct {
      logic        cmd;
      logic [15:0] value;
      logic        bad;
   } beat_type;

   typedef struct {
      logic [15:0] pix;
      logic        fixed;
      logic        lonely;
      logic        last;
   } pixel_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 0;
   logic [1:0]  csr_index = bbpmc_pkg::REG_FRAME_WIDTH;
   logic [11:0] csr_wdata = '0;

   bayer_bad_pixel_median_correct dut (.*);

   beat_type  pending_beats[$];
   pixel_type corrected_q[$];

   logic [11:0] cfg_width = 12'd1024;
   logic [11:0] cfg_height = 12'd1024;
   logic        cfg_green_even = 1'b1;
   logic [16:0] window[STORE_DEPTH];
   int          beats_in_frame = 0;
   int          col = 0;
   int          row = 0;

   int  errors = 0;
   int  checked = 0;
   int  frames = 0;
   int  pixels_sent = 0;
   int  beats_queued = 0;
   bit  idle_on = 1;
   bit  hold_req = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  recv_hold = 0;

   int ring_x[8] = '{-2, 0, 2, -2, 2, -2, 0, 2};
   int ring_y[8] = '{-2, -2, -2, 0, 0, 2, 2, 2};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb NOT OK");
      $finish;
   end

   task automatic predict_beat(input logic cmd, input logic [15:0] v, input logic b);
      int w, h, x, y, n, k, i, j, nx, ny, cnt, dx, dy, t;
      logic [16:0] c, e;
      int vals[8];
      bit green;
      pixel_type r;
      w = (cfg_width < 1) ? 1 :
          ((cfg_width > bbpmc_pkg::MAX_WIDTH) ? bbpmc_pkg::MAX_WIDTH : cfg_width);
      h = (cfg_height < 1) ? 1 : cfg_height;
      window[beats_in_frame % STORE_DEPTH] = (cmd == bbpmc_pkg::CMD_PIXEL) ? {b, v} : 17'd0;
      beats_in_frame++;
      if (beats_in_frame <= 2 * w + 2) return;
      x = col;
      y = row;
      c = window[(y * w + x) % STORE_DEPTH];
      r.pix = c[15:0];
      r.fixed = 0;
      r.lonely = 0;
      if (c[16]) begin
         green = (((x + y) & 1) == 0) == cfg_green_even;
         cnt = green ? 4 : 8;
         n = 0;
         for (k = 0; k < cnt; k++) begin
            if (green) begin
               dx = (k & 1) ? 1 : -1;
               dy = (k & 2) ? 1 : -1;
            end else begin
               dx = ring_x[k];
               dy = ring_y[k];
            end
            nx = x + dx;
            ny = y + dy;
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
            e = window[(ny * w + nx) % STORE_DEPTH];
            if (e[16]) continue;
            vals[n] = e[15:0];
            n++;
         end
         if (n == 0) begin
            r.lonely = 1;
         end else begin
            for (i = 1; i < n; i++) begin
               t = vals[i];
               j = i;
               while (j > 0 && vals[j-1] > t) begin
                  vals[j] = vals[j-1];
                  j--;
               end
               vals[j] = t;
            end
            r.pix = vals[n/2];
            r.fixed = 1;
         end
      end
      r.last = (y + 1 >= h) && (x + 1 >= w);
      if (r.last) begin
         beats_in_frame = 0;
         col = 0;
         row = 0;
      end else if (x + 1 >= w) begin
         col = 0;
         row = y + 1;
      end else begin
         col = x + 1;
      end
      corrected_q.insert(corrected_q.size(), r);
   endtask

   task automatic report(input string what, input int got, input int want);
      errors++;
      if (errors <= 20)
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // driver
   always @(posedge clock) begin
      beat_type nb;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_beat(req_tuser[0], req_tdata, req_tuser[1]);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 0;
            end else if (pending_beats.size() > 0) begin
               nb = pending_beats.pop_front();
               req_tvalid <= 1;
               req_tdata <= nb.value;
               req_tuser <= {nb.bad, nb.cmd};
               if (idle_on && $urandom_range(0, 19) == 0) send_gap = $urandom_range(1, 15);
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type x;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (corrected_q.size() == 0) begin
               report("unexpected beat", rsp_tdata, 0);
            end else begin
               x = corrected_q.pop_front();
               checked++;
               if (rsp_tdata !== x.pix) report("pixel_out", rsp_tdata, x.pix);
               if (rsp_tuser[0] !== x.fixed) report("was_corrected", rsp_tuser[0], x.fixed);
               if (rsp_tuser[1] !== x.lonely) report("no_neighbours", rsp_tuser[1], x.lonely);
               if (rsp_tlast !== x.last) report("frame_end", rsp_tlast, x.last);
            end
         end
         if (hold_req && recv_hold == 0) begin
            hold_req = 0;
            recv_hold = 400;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if (idle_on && $urandom_range(0, 19) == 0) recv_gap = $urandom_range(1, 15);
         end
      end
   end

   task automatic wait_idle();
      while (pending_beats.size() > 0 || req_tvalid || corrected_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(input logic [11:0] w, input logic [11:0] h, input logic g);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= bbpmc_pkg::REG_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= bbpmc_pkg::REG_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= bbpmc_pkg::REG_GREEN_EVEN;
      csr_wdata <= {11'd0, g};
      @(posedge clock);
      csr_wr_en <= 0;
      cfg_width = w;
      cfg_height = h;
      cfg_green_even = g;
   endtask

   // configure, then queue one frame followed by its drain beats
   task automatic push_frame(input logic [11:0] w, input logic [11:0] h, input logic g,
                             input int bad_pct, input int flush_pct, input bit extremes);
      int ew, eh, i;
      beat_type b;
      configure(w, h, g);
      ew = (w < 1) ? 1 : ((w > bbpmc_pkg::MAX_WIDTH) ? bbpmc_pkg::MAX_WIDTH : w);
      eh = (h < 1) ? 1 : h;
      for (i = 0; i < ew * eh; i++) begin
         b.cmd = ($urandom_range(0, 99) < flush_pct) ? bbpmc_pkg::CMD_FLUSH
                                                     : bbpmc_pkg::CMD_PIXEL;
         b.value = extremes ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000)
                            : 16'($urandom);
         b.bad = $urandom_range(0, 99) < bad_pct;
         pending_beats.insert(pending_beats.size(), b);
      end
      for (i = 0; i < 2 * ew + 2; i++) begin
         b.cmd = bbpmc_pkg::CMD_FLUSH;
         b.value = 16'($urandom);
         b.bad = $urandom_range(0, 1);
         pending_beats.insert(pending_beats.size(), b);
      end
      frames++;
      pixels_sent += ew * eh;
      beats_queued += ew * eh + 2 * ew + 2;
   endtask

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) window[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: lone bad pixel, dense defects at extremes, clean frame, flushes inside
      push_frame(12'd0, 12'd0, 1'b1, 100, 0, 1);
      push_frame(12'd8, 12'd3, 1'b0, 90, 0, 1);
      push_frame(12'd8, 12'd2, 1'b1, 0, 30, 0);
      push_frame(12'd1, 12'd5, 1'b0, 50, 0, 0);
      while (beats_queued < 420) begin
         push_frame(12'($urandom_range(8, 20)), 12'($urandom_range(1, 6)),
                    $urandom_range(0, 1), $urandom_range(0, 3) * 30,
                    $urandom_range(0, 1) * 3, 0);
      end
      push_frame(12'd12, 12'd4, 1'b1, 30, 0, 0);
      hold_req = 1;
      push_frame(12'd16, 12'd3, 1'b1, 40, 0, 0);
      idle_on = 0;
      push_frame(12'd8, 12'd6, 1'b0, 20, 1, 0);
      wait_idle();
      repeat (50) @(posedge clock);
      $display("covered %0d frames, %0d pixel positions in %0d input beats",
               frames, pixels_sent, beats_queued);
      $display("%0d output beats checked under stalls and back-to-back traffic", checked);
      if (errors == 0 && corrected_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bbpmc_pkg.sv
rtl/bayer_bad_pixel_median_correct.sv
tb/sv/tb.sv
